[design/obb_pkg.sv]
// Package for the oriented-box separating axis tester.
// Holds lane widths and shared vector types; used by the axis generator, the projector and the top level.
package obb_pkg;
	localparam int CW = 16;
	localparam int FIELD_W = 48;
	localparam int DW = CW + 1;
	localparam int PW = 2 * CW;
	localparam int AW = PW + 1;
	localparam int MW = AW + DW;
	localparam int SW = MW + 2;
	localparam int TW = SW + 3;
	localparam int NUM_EXT = 6;
	localparam int NUM_AXES = 15;
	localparam int NUM_CROSS = 9;
	localparam int LATENCY = 7;

	typedef logic signed [CW-1:0] comp_t;
	typedef logic signed [DW-1:0] dcomp_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [AW-1:0] acomp_t;
	typedef logic signed [MW-1:0] mprod_t;
	typedef logic signed [SW-1:0] dsum_t;
	typedef logic [SW-1:0] dmag_t;
	typedef logic [TW-1:0] rsum_t;
endpackage

[design/obb_axis_gen.sv]
// Builds the 15 candidate axes in two pipeline stages: cross partial products, then differences.
// Also carries the half-extents and center offset alongside. Depends on obb_pkg.
module obb_axis_gen (
	input  logic           clk,
	input  obb_pkg::comp_t  ext [6][3],
	input  obb_pkg::dcomp_t d [3],
	output obb_pkg::acomp_t axis [15][3],
	output obb_pkg::comp_t  ext_o [6][3],
	output obb_pkg::dcomp_t d_o [3]
);
	import obb_pkg::*;

	prod_t  pp_s2 [NUM_CROSS][6];
	comp_t  ext_s2 [NUM_EXT][3];
	dcomp_t d_s2 [3];
	acomp_t axis_s3 [NUM_AXES][3];
	comp_t  ext_s3 [NUM_EXT][3];
	dcomp_t d_s3 [3];

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				pp_s2[i*3+j][0] <= ext[i][1] * ext[3+j][2];
				pp_s2[i*3+j][1] <= ext[i][2] * ext[3+j][1];
				pp_s2[i*3+j][2] <= ext[i][2] * ext[3+j][0];
				pp_s2[i*3+j][3] <= ext[i][0] * ext[3+j][2];
				pp_s2[i*3+j][4] <= ext[i][0] * ext[3+j][1];
				pp_s2[i*3+j][5] <= ext[i][1] * ext[3+j][0];
			end
		end
		ext_s2 <= ext;
		d_s2 <= d;
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_EXT; k++) begin
			for (int c = 0; c < 3; c++) begin
				axis_s3[k][c] <= AW'(ext_s2[k][c]);
			end
		end
		for (int n = 0; n < NUM_CROSS; n++) begin
			axis_s3[NUM_EXT+n][0] <= AW'(pp_s2[n][0]) - AW'(pp_s2[n][1]);
			axis_s3[NUM_EXT+n][1] <= AW'(pp_s2[n][2]) - AW'(pp_s2[n][3]);
			axis_s3[NUM_EXT+n][2] <= AW'(pp_s2[n][4]) - AW'(pp_s2[n][5]);
		end
		ext_s3 <= ext_s2;
		d_s3 <= d_s2;
	end

	assign axis = axis_s3;
	assign ext_o = ext_s3;
	assign d_o = d_s3;
endmodule

[design/obb_proj.sv]
// Projects the center offset and six half-extents onto one axis over three stages.
// Flags the axis as separating when the offset projection exceeds the extent sum. Depends on obb_pkg.
module obb_proj (
	input  logic            clk,
	input  obb_pkg::acomp_t axis [3],
	input  obb_pkg::comp_t  ext [6][3],
	input  obb_pkg::dcomp_t d [3],
	output logic            sep
);
	import obb_pkg::*;

	mprod_t prod_s4 [7][3];
	dmag_t  mag_s5 [7];
	logic   sep_s6;
	dsum_t  dot [7];
	rsum_t  radius;

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int k = 0; k < NUM_EXT; k++) begin
				prod_s4[k][c] <= MW'(axis[c]) * MW'(ext[k][c]);
			end
			prod_s4[NUM_EXT][c] <= MW'(axis[c]) * MW'(d[c]);
		end
	end

	always_comb begin
		for (int k = 0; k < 7; k++) begin
			dot[k] = SW'(prod_s4[k][0]) + SW'(prod_s4[k][1]) + SW'(prod_s4[k][2]);
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < 7; k++) begin
			mag_s5[k] <= dot[k][SW-1] ? dmag_t'(-dot[k]) : dmag_t'(dot[k]);
		end
	end

	always_comb begin
		radius = '0;
		for (int k = 0; k < NUM_EXT; k++) begin
			radius = radius + TW'(mag_s5[k]);
		end
	end

	always_ff @(posedge clk) begin
		sep_s6 <= TW'(mag_s5[NUM_EXT]) > radius;
	end

	assign sep = sep_s6;
endmodule

[design/obb_obb_separating_axis_test.sv]
// Oriented-box overlap test on all 15 separating axes, fully pipelined.
// Throughput: one beat per cycle sustained; done marks the result of each accepted beat.
// The rate comes from a seven-stage pipeline with every axis projected in parallel.
// busy stays low, since the receiver cannot stall and every stage advances each cycle.
// Reset clears the stage valid bits and the done strobe; payload registers are not reset.
module obb_obb_separating_axis_test (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [obb_pkg::FIELD_W-1:0] a_center,
	input  logic [obb_pkg::FIELD_W-1:0] a_right,
	input  logic [obb_pkg::FIELD_W-1:0] a_up,
	input  logic [obb_pkg::FIELD_W-1:0] a_look,
	input  logic [obb_pkg::FIELD_W-1:0] b_center,
	input  logic [obb_pkg::FIELD_W-1:0] b_right,
	input  logic [obb_pkg::FIELD_W-1:0] b_up,
	input  logic [obb_pkg::FIELD_W-1:0] b_look,
	output logic                       done,
	output logic                       hit,
	output logic signed [15:0]         contact_x,
	output logic signed [15:0]         contact_y,
	output logic signed [15:0]         contact_z
);
	import obb_pkg::*;

	logic [LATENCY-1:0] vld_q;
	comp_t  ext_s1 [NUM_EXT][3];
	dcomp_t d_s1 [3];
	comp_t  mid_s1 [3];
	comp_t  mid_q [LATENCY-2][3];
	acomp_t axis [NUM_AXES][3];
	comp_t  ext_p [NUM_EXT][3];
	dcomp_t d_p [3];
	logic [NUM_AXES-1:0] sep;
	logic   hit_q;
	comp_t  cx_q, cy_q, cz_q;
	logic [FIELD_W-1:0] ext_in [NUM_EXT];
	comp_t ca [3];
	comp_t cb [3];
	dcomp_t csum [3];

	assign ext_in[0] = a_right;
	assign ext_in[1] = a_up;
	assign ext_in[2] = a_look;
	assign ext_in[3] = b_right;
	assign ext_in[4] = b_up;
	assign ext_in[5] = b_look;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			ca[c] = a_center[c*CW +: CW];
			cb[c] = b_center[c*CW +: CW];
			csum[c] = DW'(ca[c]) + DW'(cb[c]);
		end
	end

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[LATENCY-2:0], start & ~busy};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < NUM_EXT; k++) begin
			for (int c = 0; c < 3; c++) begin
				ext_s1[k][c] <= ext_in[k][c*CW +: CW];
			end
		end
		for (int c = 0; c < 3; c++) begin
			d_s1[c] <= DW'(cb[c]) - DW'(ca[c]);
			mid_s1[c] <= CW'(csum[c] >>> 1);
		end
	end

	always_ff @(posedge clk) begin
		mid_q[0] <= mid_s1;
		for (int s = 1; s < LATENCY-2; s++) begin
			mid_q[s] <= mid_q[s-1];
		end
	end

	obb_axis_gen u_axis_gen (
		.clk  (clk),
		.ext  (ext_s1),
		.d    (d_s1),
		.axis (axis),
		.ext_o(ext_p),
		.d_o  (d_p)
	);

	for (genvar g = 0; g < NUM_AXES; g++) begin : g_proj
		obb_proj u_proj (
			.clk (clk),
			.axis(axis[g]),
			.ext (ext_p),
			.d   (d_p),
			.sep (sep[g])
		);
	end

	always_ff @(posedge clk) begin
		hit_q <= ~|sep;
		cx_q <= (~|sep) ? mid_q[LATENCY-3][0] : '0;
		cy_q <= (~|sep) ? mid_q[LATENCY-3][1] : '0;
		cz_q <= (~|sep) ? mid_q[LATENCY-3][2] : '0;
	end

	assign done = vld_q[LATENCY-1];
	assign hit = hit_q;
	assign contact_x = cx_q;
	assign contact_y = cy_q;
	assign contact_z = cz_q;
endmodule

[design/obb_checker.sv]
// Port-level checker for the oriented-box tester, bound to the top level.
// Depends on obb_obb_separating_axis_test.
module obb_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        hit,
	input logic [15:0] contact_x,
	input logic [15:0] contact_y,
	input logic [15:0] contact_z
);
	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !hit) |-> (contact_x == 16'd0 && contact_y == 16'd0 && contact_z == 16'd0))
		else $error("contact nonzero on a miss beat");
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##7 done)
		else $error("accepted beat did not produce a result");
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!(start && !busy) |-> ##7 !done)
		else $error("result without an accepted beat");
endmodule

bind obb_obb_separating_axis_test obb_checker u_obb_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.start    (start),
	.busy     (busy),
	.done     (done),
	.hit      (hit),
	.contact_x(contact_x),
	.contact_y(contact_y),
	.contact_z(contact_z)
);

[bench/testbench.sv]
// Testbench for the oriented-box separating axis tester: directed and random box pairs,
// every beat checked against an in-bench predictor of the 15-axis test and midpoint.
// Depends on obb_pkg and obb_obb_separating_axis_test from the design folder.
module testbench;
	import obb_pkg::*;

	typedef struct packed {
		logic [FIELD_W-1:0] ac, ar, au, al, bc, br, bu, bl;
	} box_pair_t;

	typedef struct packed {
		logic        hit;
		logic [15:0] cx, cy, cz;
	} contact_t;

	localparam int WATCHDOG_LIMIT = 1000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [FIELD_W-1:0] a_center = '0, a_right = '0, a_up = '0, a_look = '0;
	logic [FIELD_W-1:0] b_center = '0, b_right = '0, b_up = '0, b_look = '0;
	logic done, hit;
	logic signed [15:0] contact_x, contact_y, contact_z;

	box_pair_t pair_q[$];
	contact_t  contact_q[$];
	logic beat_taken = 1'b0;
	int sent_cnt = 0;
	int accepted_cnt = 0;
	int result_cnt = 0;
	int hit_cnt = 0;
	int mismatch_cnt = 0;
	int idle_cnt = 0;
	int total_items;

	obb_obb_separating_axis_test u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.a_center(a_center), .a_right(a_right), .a_up(a_up), .a_look(a_look),
		.b_center(b_center), .b_right(b_right), .b_up(b_up), .b_look(b_look),
		.done(done), .hit(hit),
		.contact_x(contact_x), .contact_y(contact_y), .contact_z(contact_z)
	);

	always #2 clk = ~clk;

	function automatic longint lane(logic [FIELD_W-1:0] f, int i);
		logic signed [CW-1:0] v;
		v = f[i*CW +: CW];
		return longint'(v);
	endfunction

	function automatic longint abs_dot(longint l[3], longint v[3]);
		longint s;
		s = l[0] * v[0] + l[1] * v[1] + l[2] * v[2];
		return s < 0 ? -s : s;
	endfunction

	function automatic bit axis_separates(longint l[3], longint d[3], longint ext[6][3]);
		longint r;
		r = 0;
		for (int k = 0; k < 6; k++)
			r += abs_dot(l, ext[k]);
		return abs_dot(l, d) > r;
	endfunction

	function automatic contact_t predict_contact(box_pair_t p);
		longint ext[6][3];
		longint ca[3], cb[3], d[3], x[3];
		logic [FIELD_W-1:0] fields[6];
		longint s;
		contact_t r;
		bit overlap;
		fields = '{p.ar, p.au, p.al, p.br, p.bu, p.bl};
		for (int k = 0; k < 6; k++)
			for (int i = 0; i < 3; i++)
				ext[k][i] = lane(fields[k], i);
		for (int i = 0; i < 3; i++) begin
			ca[i] = lane(p.ac, i);
			cb[i] = lane(p.bc, i);
			d[i] = cb[i] - ca[i];
		end
		overlap = 1'b1;
		for (int k = 0; k < 6; k++)
			if (axis_separates(ext[k], d, ext))
				overlap = 1'b0;
		for (int i = 0; i < 3; i++)
			for (int j = 3; j < 6; j++) begin
				x[0] = ext[i][1] * ext[j][2] - ext[i][2] * ext[j][1];
				x[1] = ext[i][2] * ext[j][0] - ext[i][0] * ext[j][2];
				x[2] = ext[i][0] * ext[j][1] - ext[i][1] * ext[j][0];
				if (axis_separates(x, d, ext))
					overlap = 1'b0;
			end
		r = '0;
		r.hit = overlap;
		if (overlap) begin
			s = (ca[0] + cb[0]) >>> 1;
			r.cx = s[15:0];
			s = (ca[1] + cb[1]) >>> 1;
			r.cy = s[15:0];
			s = (ca[2] + cb[2]) >>> 1;
			r.cz = s[15:0];
		end
		return r;
	endfunction

	function automatic void enqueue_pair(box_pair_t p);
		pair_q = {pair_q, p};
	endfunction

	function automatic logic [FIELD_W-1:0] pack3(int x, int y, int z);
		logic [FIELD_W-1:0] f;
		f[15:0] = x[15:0];
		f[31:16] = y[15:0];
		f[47:32] = z[15:0];
		return f;
	endfunction

	function automatic int srand(int span);
		return int'($urandom_range(2 * span)) - span;
	endfunction

	function automatic box_pair_t aligned_pair(int ax, int ay, int az, int bx, int by, int bz,
			int dx, int dy, int dz);
		box_pair_t p;
		p.ac = pack3(srand(256), srand(256), srand(256));
		p.ar = pack3(ax, 0, 0);
		p.au = pack3(0, ay, 0);
		p.al = pack3(0, 0, az);
		p.bc = pack3(int'(p.ac[15:0]) + dx, int'(p.ac[31:16]) + dy, int'(p.ac[47:32]) + dz);
		p.br = pack3(bx, 0, 0);
		p.bu = pack3(0, by, 0);
		p.bl = pack3(0, 0, bz);
		return p;
	endfunction

	// Sender idles 37 percent in the first third of the run, 55 in the second, never after.
	function automatic int sender_idle_pct();
		if (sent_cnt < total_items / 3)
			return 37;
		if (sent_cnt < 2 * total_items / 3)
			return 55;
		return 0;
	endfunction

	always @(negedge clk) begin
		if (arst_n) begin
			if (start && !beat_taken) begin
				start <= 1'b1;
			end else if (pair_q.size() > 0 && int'($urandom_range(99)) >= sender_idle_pct()) begin
				box_pair_t p;
				p = pair_q.pop_front();
				sent_cnt++;
				{a_center, a_right, a_up, a_look} <= {p.ac, p.ar, p.au, p.al};
				{b_center, b_right, b_up, b_look} <= {p.bc, p.br, p.bu, p.bl};
				start <= 1'b1;
			end else begin
				start <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			beat_taken <= start && !busy;
			if (start && !busy) begin
				contact_q = {contact_q, predict_contact({a_center, a_right, a_up, a_look,
					b_center, b_right, b_up, b_look})};
				accepted_cnt++;
			end
			if (done) begin
				contact_t exp_c;
				result_cnt++;
				if (hit)
					hit_cnt++;
				if (contact_q.size() == 0) begin
					mismatch_cnt++;
					if (mismatch_cnt <= 10)
						$display("unexpected result beat: hit=%0b", hit);
				end else begin
					exp_c = contact_q.pop_front();
					if (exp_c !== {hit, contact_x, contact_y, contact_z}) begin
						mismatch_cnt++;
						if (mismatch_cnt <= 10)
							$display("result %0d: expected hit=%0b c=%h,%h,%h got hit=%0b c=%h,%h,%h",
								result_cnt, exp_c.hit, exp_c.cx, exp_c.cy, exp_c.cz,
								hit, contact_x, contact_y, contact_z);
					end
				end
			end
			if ((start && !busy) || done)
				idle_cnt <= 0;
			else
				idle_cnt <= idle_cnt + 1;
			if (idle_cnt >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	initial begin
		box_pair_t p;
		int e[6];
		int mode;
		p = '0;
		enqueue_pair(p);
		p = {8{48'h8000_8000_8000}};
		enqueue_pair(p);
		p = {8{48'h7FFF_7FFF_7FFF}};
		enqueue_pair(p);
		p = {8{48'hFFFF_FFFF_FFFF}};
		enqueue_pair(p);
		p = {48'h8000_8000_8000, {3{48'h7FFF_7FFF_7FFF}}, 48'h7FFF_7FFF_7FFF,
			{3{48'h8000_8000_8000}}};
		enqueue_pair(p);
		enqueue_pair(aligned_pair(256, 256, 256, 256, 256, 256, 512, 0, 0));
		enqueue_pair(aligned_pair(256, 256, 256, 256, 256, 256, 513, 0, 0));
		enqueue_pair(aligned_pair(256, 128, 64, 32, 16, 8, 0, -144, 0));
		enqueue_pair(aligned_pair(256, 128, 64, 32, 16, 8, 0, 0, -73));
		enqueue_pair(aligned_pair(0, 0, 0, 0, 0, 0, 0, 0, 0));
		enqueue_pair(aligned_pair(0, 0, 0, 0, 0, 0, 1, 0, 0));
		enqueue_pair(aligned_pair(100, 100, 100, 100, 100, 100, -3, -5, 7));
		p = '0;
		p.ac = pack3(-3, 5, -1);
		p.bc = pack3(0, 0, 0);
		enqueue_pair(p);
		p.ar = pack3(100, 100, 0);
		p.au = pack3(-100, 100, 0);
		p.al = pack3(0, 0, 50);
		p.br = pack3(100, 0, 0);
		p.bu = pack3(0, 100, 0);
		p.bl = pack3(0, 0, 100);
		p.bc = pack3(250, 0, 0);
		enqueue_pair(p);
		p.bc = pack3(350, 0, 0);
		enqueue_pair(p);
		for (int n = 0; n < 800; n++) begin
			mode = $urandom_range(99);
			if (mode < 15) begin
				p = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom, $urandom};
			end else if (mode < 40) begin
				foreach (e[k])
					e[k] = $urandom_range(600);
				p = aligned_pair(e[0], e[1], e[2], e[3], e[4], e[5],
					(e[0] + e[3]) * ($urandom_range(1) ? 1 : -1) + srand(1),
					srand(e[1] + e[4]), srand(e[2] + e[5]));
			end else begin
				p.ac = pack3(srand(1024), srand(1024), srand(1024));
				p.bc = pack3(srand(1024), srand(1024), srand(1024));
				p.ar = pack3(srand(512), srand(512), srand(512));
				p.au = pack3(srand(512), srand(512), srand(512));
				p.al = pack3(srand(512), srand(512), srand(512));
				p.br = pack3(srand(512), srand(512), srand(512));
				p.bu = pack3(srand(512), srand(512), srand(512));
				p.bl = pack3(srand(512), srand(512), srand(512));
			end
			enqueue_pair(p);
		end
		total_items = pair_q.size();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		do @(posedge clk); while (pair_q.size() > 0 || (start && !beat_taken));
		while (contact_q.size() > 0)
			@(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
		$display("Checked %0d box pairs, %0d results, %0d overlaps, %0d mismatches.",
			accepted_cnt, result_cnt, hit_cnt, mismatch_cnt);
		if (mismatch_cnt == 0 && contact_q.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end
endmodule
